[src/jls_pkg.sv]
// shared types and constants for the jacobi solver core
package jls_pkg;

  localparam int DIM = 8;
  localparam int IW  = $clog2(DIM);
  localparam int AW  = $clog2(DIM * DIM);
  localparam int CW  = 10;
  localparam int DCW = 6;

  localparam logic [1:0] ST_CONV  = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_ZDIAG = 2'd2;

  localparam logic REG_TOL = 1'b0;
  localparam logic REG_LIM = 1'b1;

  typedef struct packed {
    logic          load;
    logic          init;
    logic          diag_rd;
    logic          sweep_start;
    logic          row_start;
    logic          mac_issue;
    logic          num;
    logic          div_step;
    logic          wr;
    logic          sq;
    logic          sq_last;
    logic          emit;
    logic          status_en;
    logic [1:0]    status_code;
    logic [IW-1:0] i;
    logic [IW-1:0] j;
  } jls_cmd_t;

  typedef struct packed {
    logic diag_zero;
    logic norm_gt_tol;
    logic cnt_lt_lim;
    logic mac_busy;
  } jls_stat_t;

endpackage

[src/jls_ram.sv]
// generic single write port ram with registered read
module jls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/jls_ctrl.sv]
// sequencer for load, diagonal check, sweeps and result output
module jls_ctrl import jls_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      last,
  output logic      busy,
  input  jls_stat_t stat,
  output jls_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_DRD, S_DCK, S_CHK, S_ROW, S_MAC, S_MACD,
    S_NUM, S_DIV, S_WR, S_SQ, S_EMIT
  } state_t;

  state_t        state;
  logic [IW-1:0] i;
  logic [IW-1:0] j;
  logic [DCW-1:0] dcnt;
  logic          zd;
  logic          zd_next;
  logic          i_end;
  logic          run;

  assign i_end   = (i == IW'(DIM - 1));
  assign zd_next = zd | stat.diag_zero;
  assign run     = stat.norm_gt_tol & stat.cnt_lt_lim;
  assign busy    = (state != S_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.i           = i;
    cmd.j           = j;
    cmd.load        = (state == S_IDLE) && start;
    cmd.init        = (state == S_INIT);
    cmd.diag_rd     = (state == S_DRD);
    cmd.sweep_start = (state == S_CHK) && run;
    cmd.row_start   = (state == S_ROW);
    cmd.mac_issue   = (state == S_MAC);
    cmd.num         = (state == S_NUM);
    cmd.div_step    = (state == S_DIV);
    cmd.wr          = (state == S_WR);
    cmd.sq          = (state == S_SQ);
    cmd.sq_last     = (state == S_SQ) && i_end;
    cmd.emit        = (state == S_EMIT);
    if (state == S_DCK && i_end && zd_next) begin
      cmd.status_en   = 1'b1;
      cmd.status_code = ST_ZDIAG;
    end else if (state == S_CHK && !run) begin
      cmd.status_en   = 1'b1;
      cmd.status_code = stat.norm_gt_tol ? ST_LIMIT : ST_CONV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
      j     <= '0;
      dcnt  <= '0;
      zd    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start && last) begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          i     <= '0;
          zd    <= 1'b0;
          state <= S_DRD;
        end
        S_DRD: state <= S_DCK;
        S_DCK: begin
          zd <= zd_next;
          if (i_end) begin
            i     <= '0;
            state <= zd_next ? S_EMIT : S_CHK;
          end else begin
            i     <= i + 1'b1;
            state <= S_DRD;
          end
        end
        S_CHK: begin
          i     <= '0;
          state <= run ? S_ROW : S_EMIT;
        end
        S_ROW: begin
          j     <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          if (j == IW'(DIM - 1)) begin
            state <= S_MACD;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_MACD: begin
          if (!stat.mac_busy) begin
            state <= S_NUM;
          end
        end
        S_NUM: begin
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          dcnt <= dcnt + 1'b1;
          if (dcnt == '1) begin
            state <= S_WR;
          end
        end
        S_WR: state <= S_SQ;
        S_SQ: begin
          if (i_end) begin
            state <= S_CHK;
          end else begin
            i     <= i + 1'b1;
            state <= S_ROW;
          end
        end
        S_EMIT: begin
          if (i_end) begin
            i     <= '0;
            state <= S_IDLE;
          end else begin
            i <= i + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last) |=> busy)
    else $error("solve did not start on last beat");

  a_div_stay: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |=> (state == S_DIV || state == S_WR))
    else $error("divider left early");

  a_mac_seq: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC) |=> (state == S_MAC || state == S_MACD))
    else $error("row accumulate broken");

endmodule

[src/jls_dpath.sv]
// stores, multiply accumulate, divider and change norm for the solver
module jls_dpath import jls_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  jls_cmd_t           cmd,
  output jls_stat_t          stat,
  input  logic [2:0]         row,
  input  logic [3:0]         col,
  input  logic signed [31:0] value,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_data,
  output logic signed [31:0] x_value,
  output logic [2:0]         x_index,
  output logic [CW-1:0]      sweeps,
  output logic [1:0]         status,
  output logic               final_res,
  output logic               result_valid
);

  localparam int BW = $clog2(2 * DIM);
  localparam logic signed [64:0] SAT_HI = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SAT_LO = -SAT_HI;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > SAT_HI) return SAT_HI[63:0];
    if (s < SAT_LO) return SAT_LO[63:0];
    return s[63:0];
  endfunction

  function automatic logic [BW-1:0] bidx(input logic bank, input logic [IW-1:0] idx);
    return BW'(bank) * BW'(DIM) + BW'(idx);
  endfunction

  logic [63:0]        tol;
  logic [CW-1:0]      lim;
  logic signed [31:0] rhs [DIM];
  logic signed [31:0] xbuf [2*DIM];
  logic [CW-1:0]      sweep_cnt;
  logic [63:0]        norm;
  logic [63:0]        sum;
  logic signed [63:0] acc;
  logic               v1, v2, use2;
  logic [IW-1:0]      j1;
  logic signed [31:0] x1;
  logic signed [63:0] prod;
  logic signed [31:0] diag;
  logic [63:0]        nm;
  logic [31:0]        dm;
  logic [31:0]        rem;
  logic [63:0]        q;
  logic               neg;
  logic [63:0]        sq;
  logic               big;
  logic [1:0]         status_q;

  logic               ram_we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [31:0]        rdq;
  logic               nw;

  logic signed [63:0] bq;
  logic signed [63:0] nval;
  logic [32:0]        remsh;
  logic               qbit;
  logic signed [31:0] xnew;
  logic signed [31:0] xold;
  logic signed [32:0] d;
  logic [32:0]        m;
  logic [64:0]        s65;
  logic [63:0]        sum_next;

  assign nw     = sweep_cnt[0];
  assign ram_we = cmd.load && (int'(row) < DIM) && (int'(col) < DIM);
  assign waddr  = AW'(row) * AW'(DIM) + AW'(col);
  assign raddr  = cmd.diag_rd ? AW'(cmd.i) * AW'(DIM) + AW'(cmd.i)
                              : AW'(cmd.i) * AW'(DIM) + AW'(cmd.j);

  jls_ram #(.WIDTH(32), .DEPTH(DIM * DIM)) u_coef (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (value),
    .raddr (raddr),
    .rdata (rdq)
  );

  always_comb begin
    bq    = {{16{rhs[cmd.i][31]}}, rhs[cmd.i], 16'b0};
    nval  = sat_add(bq, -acc);
    remsh = {rem, nm[63]};
    qbit  = (remsh >= {1'b0, dm});
    if (neg) begin
      xnew = (q >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
    end else begin
      xnew = (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    end
    xold     = xbuf[bidx(~nw, cmd.i)];
    d        = 33'(xnew) - 33'(xold);
    m        = d[32] ? 33'(-d) : 33'(d);
    s65      = {1'b0, sum} + {1'b0, (big ? 64'hFFFF_FFFF_FFFF_FFFF : sq)};
    sum_next = s65[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s65[63:0];
  end

  assign stat.diag_zero   = (rdq == 32'd0);
  assign stat.norm_gt_tol = (norm > tol);
  assign stat.cnt_lt_lim  = (sweep_cnt < lim);
  assign stat.mac_busy    = v1 | v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol          <= 64'd1;
      lim          <= CW'(100);
      sweep_cnt    <= '0;
      norm         <= '1;
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
      status_q     <= ST_CONV;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TOL: tol <= cfg_data;
          REG_LIM: lim <= cfg_data[CW-1:0];
          default: ;
        endcase
      end
      v1           <= cmd.mac_issue;
      v2           <= v1;
      result_valid <= cmd.emit;
      if (cmd.init) begin
        sweep_cnt <= '0;
        norm      <= '1;
      end
      if (cmd.sweep_start) begin
        sweep_cnt <= sweep_cnt + 1'b1;
      end
      if (cmd.sq_last) begin
        norm <= sum_next;
      end
      if (cmd.status_en) begin
        status_q <= cmd.status_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (int'(row) < DIM) && (int'(col) == DIM)) begin
      rhs[IW'(row)] <= value;
    end
    if (cmd.init) begin
      for (int k = 0; k < 2 * DIM; k++) begin
        xbuf[k] <= '0;
      end
    end
    if (cmd.sweep_start) begin
      sum <= '0;
    end
    if (cmd.row_start) begin
      acc <= '0;
    end
    if (cmd.mac_issue) begin
      x1 <= xbuf[bidx(~nw, cmd.j)];
      j1 <= cmd.j;
    end
    if (v1) begin
      prod <= $signed(rdq) * x1;
      use2 <= (j1 != cmd.i);
      if (j1 == cmd.i) begin
        diag <= $signed(rdq);
      end
    end
    if (v2 && use2) begin
      acc <= sat_add(acc, prod);
    end
    if (cmd.num) begin
      nm  <= nval[63] ? 64'(-nval) : 64'(nval);
      dm  <= diag[31] ? 32'(-diag) : 32'(diag);
      neg <= nval[63] ^ diag[31];
      rem <= '0;
      q   <= '0;
    end
    if (cmd.div_step) begin
      rem <= qbit ? 32'(remsh - {1'b0, dm}) : remsh[31:0];
      q   <= {q[62:0], qbit};
      nm  <= {nm[62:0], 1'b0};
    end
    if (cmd.wr) begin
      xbuf[bidx(nw, cmd.i)] <= xnew;
      big <= m[32];
      sq  <= 64'(m[31:0]) * 64'(m[31:0]);
    end
    if (cmd.sq) begin
      sum <= sum_next;
    end
    if (cmd.emit) begin
      x_value   <= xbuf[bidx(nw, cmd.i)];
      x_index   <= 3'(cmd.i);
      sweeps    <= sweep_cnt;
      status    <= status_q;
      final_res <= (cmd.i == IW'(DIM - 1));
    end
  end

  a_final_idx: assert property (@(posedge clk) disable iff (rst)
    (result_valid && final_res) |-> (x_index == 3'(DIM - 1)))
    else $error("final beat on wrong index");

  a_zdiag_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == ST_ZDIAG) |-> (x_value == 32'sd0 && sweeps == '0))
    else $error("zero diagonal result not cleared");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !final_res) |=> result_valid)
    else $error("result burst broken");

endmodule

[src/jacobi_linear_solver_core.sv]
// top level of the jacobi solver core
// load: one entry beat per cycle, busy stays low until a beat with last
// solve after last: the sweeps are paced by the radix-2 divider
// (64 steps per component) and the serial row mac
// then DIM result beats on consecutive cycles, each registered from the sequencer
// rst is synchronous: config back to defaults, sequencer idle, coefficients kept
module jacobi_linear_solver_core import jls_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         row,
  input  logic [3:0]         col,
  input  logic signed [31:0] value,
  input  logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_data,
  output logic               result_valid,
  output logic signed [31:0] x_value,
  output logic [2:0]         x_index,
  output logic [CW-1:0]      sweeps,
  output logic [1:0]         status,
  output logic               final_res
);

  jls_cmd_t  cmd;
  jls_stat_t stat;

  assign cfg_ready = 1'b1;

  jls_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .last  (last),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  jls_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .row          (row),
    .col          (col),
    .value        (value),
    .cfg_we       (cfg_valid & cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .x_value      (x_value),
    .x_index      (x_index),
    .sweeps       (sweeps),
    .status       (status),
    .final_res    (final_res),
    .result_valid (result_valid)
  );

endmodule

[tb/jacobi_linear_solver_core_chk.sv]
// checker for the jacobi solver core: predicts each solve and compares result beats
`timescale 1ns / 1ps
module jacobi_linear_solver_core_chk import jls_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         row,
  input  logic [3:0]         col,
  input  logic signed [31:0] value,
  input  logic               last,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               result_valid,
  input  logic signed [31:0] x_value,
  input  logic [2:0]         x_index,
  input  logic [CW-1:0]      sweeps,
  input  logic [1:0]         status,
  input  logic               final_res,
  output int                 errors,
  output int                 pending
);

  localparam longint SAT_POS = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SAT_NEG = -SAT_POS;

  typedef struct packed {
    logic signed [31:0] x;
    logic [2:0]         idx;
    logic [CW-1:0]      sw;
    logic [1:0]         st;
    logic               fin;
  } x_beat_t;

  logic signed [31:0] coef [DIM*DIM];
  logic signed [31:0] rhs [DIM];
  logic [63:0]        tol_sq;
  logic [CW-1:0]      sweep_lim;
  x_beat_t            solution_q [$];

  function automatic longint sat_sum(longint a, longint b);
    if (b > 0 && a > SAT_POS - b) return SAT_POS;
    if (b < 0 && a < SAT_NEG - b) return SAT_NEG;
    return a + b;
  endfunction

  function automatic logic signed [31:0] q16_div(longint num, logic signed [31:0] den);
    logic [63:0] nm, dm, q;
    logic        neg;
    nm = (num < 0) ? 64'(-num) : 64'(num);
    dm = (den < 0) ? 64'(-longint'(den)) : 64'(longint'(den));
    neg = (num < 0) != (den < 0);
    q = nm / dm;
    if (neg) return (q >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-longint'(q));
    return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
  endfunction

  function automatic void solve_system();
    logic signed [31:0] xb [2][DIM];
    int          cnt, nw, od, cur;
    logic [63:0] norm, sum, m, sq;
    logic [1:0]  st;
    logic        zd;
    longint      acc, num, d;
    x_beat_t     e;
    cnt = 0; cur = 0; norm = '1; zd = 0;
    for (int i = 0; i < DIM; i++) begin
      xb[0][i] = 0;
      xb[1][i] = 0;
      if (coef[i*DIM+i] == 0) zd = 1;
    end
    if (zd) begin
      st = ST_ZDIAG;
    end else begin
      while (norm > tol_sq && cnt < sweep_lim) begin
        nw = (cnt + 1) & 1;
        od = nw ^ 1;
        cnt++;
        for (int i = 0; i < DIM; i++) begin
          acc = 0;
          for (int j = 0; j < DIM; j++)
            if (j != i) acc = sat_sum(acc, longint'(coef[i*DIM+j]) * longint'(xb[od][j]));
          num = sat_sum(longint'(rhs[i]) * 65536, -acc);
          xb[nw][i] = q16_div(num, coef[i*DIM+i]);
        end
        sum = 0;
        for (int i = 0; i < DIM; i++) begin
          d = longint'(xb[nw][i]) - longint'(xb[od][i]);
          m = (d < 0) ? 64'(-d) : 64'(d);
          sq = (m >= 64'h1_0000_0000) ? '1 : m * m;
          sum = (sum > ~sq) ? '1 : sum + sq;
        end
        norm = sum;
        cur = nw;
      end
      st = (norm <= tol_sq) ? ST_CONV : ST_LIMIT;
    end
    for (int i = 0; i < DIM; i++) begin
      e.x = (cnt == 0) ? 32'sd0 : xb[cur][i];
      e.idx = 3'(i);
      e.sw = CW'(cnt);
      e.st = st;
      e.fin = (i == DIM - 1);
      solution_q.push_back(e);
    end
  endfunction

  initial begin
    errors = 0;
    tol_sq = 64'd1;
    sweep_lim = CW'(100);
  end

  assign pending = solution_q.size();

  always @(posedge clk) begin
    x_beat_t e;
    if (rst) begin
      tol_sq = 64'd1;
      sweep_lim = CW'(100);
    end else begin
      if (result_valid) begin
        if (solution_q.size() == 0) begin
          $error("result beat with nothing expected: x_index %0d", x_index);
          errors++;
        end else begin
          e = solution_q.pop_front();
          if (x_value !== e.x) begin
            $error("x_value: expected %0d, got %0d", e.x, x_value); errors++;
          end
          if (x_index !== e.idx) begin
            $error("x_index: expected %0d, got %0d", e.idx, x_index); errors++;
          end
          if (sweeps !== e.sw) begin
            $error("sweeps: expected %0d, got %0d", e.sw, sweeps); errors++;
          end
          if (status !== e.st) begin
            $error("status: expected %0d, got %0d", e.st, status); errors++;
          end
          if (final_res !== e.fin) begin
            $error("final_res: expected %0d, got %0d", e.fin, final_res); errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TOL) tol_sq = cfg_data;
        else sweep_lim = cfg_data[CW-1:0];
      end
      if (start && !busy) begin
        if (col < DIM) coef[row*DIM+col] = value;
        else if (col == DIM) rhs[row] = value;
        if (last) solve_system();
      end
    end
  end

endmodule

[tb/jacobi_linear_solver_core_tb.sv]
// testbench top for the jacobi solver core: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module jacobi_linear_solver_core_tb;
  import jls_pkg::*;

  localparam int WATCHDOG_LIMIT = 300000;

  logic               clk, rst, start, busy, last;
  logic [2:0]         row;
  logic [3:0]         col;
  logic signed [31:0] value;
  logic               cfg_valid, cfg_ready, cfg_index;
  logic [63:0]        cfg_data;
  logic               result_valid, final_res;
  logic signed [31:0] x_value;
  logic [2:0]         x_index;
  logic [CW-1:0]      sweeps;
  logic [1:0]         status;
  int                 errors, pending, idle_cycles, gap_pct, items;

  jacobi_linear_solver_core uut (.*);
  jacobi_linear_solver_core_chk chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || result_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("jacobi_linear_solver_core regression: fail");
    $finish;
  end

  task automatic send_entry(input int r, input int c, input logic [31:0] v, input bit l);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    start <= 1'b1;
    row <= 3'(r);
    col <= 4'(c);
    value <= v;
    last <= l;
    do @(posedge clk); while (busy);
    items++;
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // diagonally dominant entries keep sweeps converging
  function automatic logic [31:0] dom_entry(int r, int c);
    logic [31:0] v;
    if (c == r) begin
      v = 32'($urandom_range(4 << 16, 2 << 16));
      return $urandom_range(1) ? v : -v;
    end
    if (c == DIM) return 32'(int'($urandom_range(32'h0100_0000)) - 32'h0080_0000);
    return 32'(int'($urandom_range(32'h8000)) - 32'h4000);
  endfunction

  task automatic load_full(input bit l);
    for (int r = 0; r < DIM; r++)
      for (int c = 0; c <= DIM; c++)
        send_entry(r, c, dom_entry(r, c), l && r == DIM - 1 && c == DIM);
  endtask

  task automatic random_solve();
    int n, r, c;
    n = $urandom_range(8, 1);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(DIM - 1);
      if ($urandom_range(99) < 80) begin
        c = $urandom_range(DIM);
        send_entry(r, c, dom_entry(r, c), k == n - 1);
      end else begin
        c = $urandom_range(15);
        send_entry(r, c, $urandom, k == n - 1);
      end
    end
    wait_quiet();
  endtask

  initial begin
    rst = 1; start = 0; row = 0; col = 0; value = 0; last = 0;
    cfg_valid = 0; cfg_index = REG_TOL; cfg_data = 0;
    gap_pct = 0; items = 0; idle_cycles = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_full(1);
    wait_quiet();
    send_entry(2, 2, 32'd0, 1);
    wait_quiet();
    send_entry(2, 9, $urandom, 0);
    send_entry(5, 15, $urandom, 0);
    send_entry(2, 2, 32'sh0003_0000, 0);
    send_entry(7, DIM, 32'sh7FFF_FFFF, 0);
    send_entry(6, DIM, 32'sh8000_0000, 0);
    send_entry(0, 11, 32'd0, 1);
    wait_quiet();
    write_reg(REG_TOL, '1);
    write_reg(REG_LIM, 10'd1023);
    send_entry(1, DIM, 32'hFFFF_FFFF, 1);
    wait_quiet();
    write_reg(REG_TOL, 64'd0);
    write_reg(REG_LIM, 10'd0);
    send_entry(3, 4, 32'sh0000_0001, 1);
    wait_quiet();
    write_reg(REG_LIM, 10'd3);
    send_entry(4, 4, 32'sh0000_0001, 0);
    send_entry(4, 0, 32'sh7FFF_FFFF, 1);
    wait_quiet();
    send_entry(4, 4, 32'sh8000_0000, 0);
    send_entry(4, 0, 32'sh8000_0000, 1);
    wait_quiet();
    write_reg(REG_LIM, 10'd1);
    send_entry(0, 0, 32'sh0002_0000, 0);
    send_entry(4, 0, 32'sh0000_0100, 0);
    send_entry(4, 4, 32'sh0003_0000, 1);
    wait_quiet();

    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = (ph == 1) ? 50 : (ph == 3) ? 31 : 0;
      case ($urandom_range(3))
        0: write_reg(REG_TOL, 64'd0);
        1: write_reg(REG_TOL, 64'd1);
        2: write_reg(REG_TOL, {32'd0, $urandom});
        default: write_reg(REG_TOL, {$urandom, $urandom});
      endcase
      write_reg(REG_LIM, 10'($urandom_range(16, 1)));
      if (ph == 2) begin
        load_full(1);
        wait_quiet();
      end
      while (items < 100 * (ph + 1) + 40) random_solve();
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("jacobi_linear_solver_core regression: pass");
    else
      $display("jacobi_linear_solver_core regression: fail");
    $finish;
  end

endmodule

[jacobi_linear_solver_core.f]
src/jls_pkg.sv
src/jls_ram.sv
src/jls_ctrl.sv
src/jls_dpath.sv
src/jacobi_linear_solver_core.sv
tb/jacobi_linear_solver_core_chk.sv
tb/jacobi_linear_solver_core_tb.sv
